// ===== rtl/bpa_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package bpa_pkg;

   localparam int NUM_PAGES = 1024;
   localparam int PAGE_W    = 10;
   localparam int CNT_W     = 11;
   localparam int MAX_ORDER = 10;
   localparam int NUM_LISTS = MAX_ORDER + 1;
   localparam int ORD_W     = 4;
   localparam int SORD_W    = 5;
   localparam int REF_W     = 16;
   localparam int STAT_W    = 3;

   localparam logic [SORD_W-1:0] ORDER_NONE = 5'd31;
   localparam logic [REF_W-1:0]  REF_MAX    = 16'hFFFF;
   localparam logic [CNT_W-1:0]  TOTAL_RST  = 11'd1024;

   typedef enum logic [1:0] {
      MODE_INIT   = 2'd0,
      MODE_ALLOC  = 2'd1,
      MODE_FREE   = 2'd2,
      MODE_ADDREF = 2'd3
   } mode_type;

   typedef enum logic [STAT_W-1:0] {
      ST_OK      = 3'd0,
      ST_REFD    = 3'd1,
      ST_NOMEM   = 3'd2,
      ST_INVALID = 3'd3,
      ST_DOUBLE  = 3'd4
   } status_type;

   typedef enum logic [3:0] {
      S_CLEAR,
      S_IDLE,
      S_CARVE,
      S_ALLOC_RM,
      S_SPLIT,
      S_ALLOC_DONE,
      S_CHECK,
      S_MERGE,
      S_MERGE_RD,
      S_PUSH,
      S_RESP
   } state_type;

   typedef struct packed {
      logic [SORD_W-1:0] order;
      logic              free;
      logic [REF_W-1:0]  refs;
   } meta_type;

   localparam int META_W = $bits(meta_type);

   typedef struct packed {
      logic             found;
      logic [ORD_W-1:0] idx;
   } avail_type;

   function automatic logic [ORD_W-1:0] high_bit(input logic [CNT_W-1:0] v);
      logic [ORD_W-1:0] r;
      r = '0;
      for (int k = 0; k < CNT_W; k++) begin
         if (v[k]) r = ORD_W'(k);
      end
      return r;
   endfunction

   function automatic avail_type first_avail(input logic [NUM_LISTS-1:0] map,
                                             input logic [ORD_W-1:0] want);
      avail_type a;
      a = '0;
      for (int k = NUM_LISTS - 1; k >= 0; k--) begin
         if (map[k] && (ORD_W'(k) >= want)) begin
            a.found = 1'b1;
            a.idx   = ORD_W'(k);
         end
      end
      return a;
   endfunction

endpackage

`default_nettype wire

// ===== rtl/bpa_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface bpa_req_if import bpa_pkg::*;;
   logic              valid;
   logic              ready;
   logic [1:0]        mode;
   logic [CNT_W-1:0]  request_pages;
   logic [PAGE_W-1:0] page_number;
   modport source (output valid, mode, request_pages, page_number, input ready);
   modport sink   (input valid, mode, request_pages, page_number, output ready);
endinterface

interface bpa_rsp_if import bpa_pkg::*;;
   logic              valid;
   logic              ready;
   logic [STAT_W-1:0] status;
   logic [PAGE_W-1:0] result_page;
   logic [ORD_W-1:0]  result_order;
   modport source (output valid, status, result_page, result_order, input ready);
   modport sink   (input valid, status, result_page, result_order, output ready);
endinterface

interface bpa_csr_if import bpa_pkg::*;;
   logic             valid;
   logic             ready;
   logic [CNT_W-1:0] total_pages;
   modport source (output valid, total_pages, input ready);
   modport sink   (input valid, total_pages, output ready);
endinterface

`default_nettype wire

// ===== rtl/bpa_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none

module bpa_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1024
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (we) mem_ff[wr_addr] <= wr_data;
   end

   always_ff @(posedge clock) begin
      rd_data <= mem_ff[rd_addr];
   end

endmodule

`default_nettype wire

// ===== rtl/buddy_page_allocator.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Buddy allocator over page frame numbers. One transaction at a time: req_bus.ready
// is high only when the sequencer is idle, while the previous response may still
// wait in the output register. Per-page order, free mark and reference count live
// in one single-port-write RAM, the list links in two more; every step of a split
// or merge is one sequencer state. Allocate unlinks the block, splits off one buddy
// per level and writes the page's order and reference count, or goes straight
// to the response when it fails. Add reference, a free that leaves the block
// referenced and a double free check the page's entry; a page outside the pool
// goes straight to the response; a released block merges with free buddies.
// Init clears all 1024 entries of the page RAM and then carves one block per cycle.
// After reset the same clearing pass runs before the first request.
module buddy_page_allocator import bpa_pkg::*; (
   input wire logic clock,
   input wire logic reset,
   bpa_req_if.sink   req_bus,
   bpa_rsp_if.source rsp_bus,
   bpa_csr_if.sink   csr_bus
);

   state_type         state_ff, state_in;
   mode_type          mode_ff, mode_in;
   logic              init_ff, init_in;
   logic [CNT_W-1:0]  idx_ff, idx_in;
   logic [CNT_W-1:0]  left_ff, left_in;
   logic [CNT_W-1:0]  pool_ff, pool_in;
   logic [CNT_W-1:0]  total_ff, total_in;
   logic [NUM_LISTS-1:0] nonempty_ff, nonempty_in;
   logic [PAGE_W-1:0] head_ff [NUM_LISTS];
   logic [PAGE_W-1:0] head_in [NUM_LISTS];
   logic [PAGE_W-1:0] tail_ff [NUM_LISTS];
   logic [PAGE_W-1:0] tail_in [NUM_LISTS];
   logic [PAGE_W-1:0] p_ff, p_in;
   logic [PAGE_W-1:0] b_ff, b_in;
   logic [ORD_W-1:0]  o_ff, o_in;
   logic [ORD_W-1:0]  want_ff, want_in;
   status_type        res_status_ff, res_status_in;
   logic [PAGE_W-1:0] res_page_ff, res_page_in;
   logic [ORD_W-1:0]  res_order_ff, res_order_in;
   logic              rsp_valid_ff, rsp_valid_in;
   status_type        rsp_status_ff, rsp_status_in;
   logic [PAGE_W-1:0] rsp_page_ff, rsp_page_in;
   logic [ORD_W-1:0]  rsp_order_ff, rsp_order_in;

   logic              meta_we;
   logic [PAGE_W-1:0] meta_wa, meta_ra;
   meta_type          meta_wd, meta_rd;
   logic [META_W-1:0] meta_rd_raw;
   logic              prev_we, next_we;
   logic [PAGE_W-1:0] prev_wa, prev_wd, next_wa, next_wd;
   logic [PAGE_W-1:0] link_ra, prev_rd, next_rd;

   logic              push_en, rm_en;
   logic [PAGE_W-1:0] push_pg, rm_pg;
   logic [ORD_W-1:0]  push_ord, rm_ord;

   logic              req_fire;
   logic [ORD_W-1:0]  hb_req, want_c, hb_left, carve_ord;
   avail_type         avail;
   logic [PAGE_W-1:0] buddy;
   logic [REF_W-1:0]  ref_dec;

   assign req_bus.ready = (state_ff == S_IDLE);
   assign req_fire      = req_bus.valid && req_bus.ready;
   assign csr_bus.ready = 1'b1;

   assign rsp_bus.valid        = rsp_valid_ff;
   assign rsp_bus.status       = rsp_status_ff;
   assign rsp_bus.result_page  = rsp_page_ff;
   assign rsp_bus.result_order = rsp_order_ff;

   assign meta_rd = meta_type'(meta_rd_raw);

   bpa_ram #(.WIDTH(META_W), .DEPTH(NUM_PAGES)) u_meta_ram (
      .clock(clock), .we(meta_we), .wr_addr(meta_wa), .wr_data(META_W'(meta_wd)),
      .rd_addr(meta_ra), .rd_data(meta_rd_raw)
   );

   bpa_ram #(.WIDTH(PAGE_W), .DEPTH(NUM_PAGES)) u_prev_ram (
      .clock(clock), .we(prev_we), .wr_addr(prev_wa), .wr_data(prev_wd),
      .rd_addr(link_ra), .rd_data(prev_rd)
   );

   bpa_ram #(.WIDTH(PAGE_W), .DEPTH(NUM_PAGES)) u_next_ram (
      .clock(clock), .we(next_we), .wr_addr(next_wa), .wr_data(next_wd),
      .rd_addr(link_ra), .rd_data(next_rd)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         init_ff      <= 1'b0;
         idx_ff       <= '0;
         pool_ff      <= '0;
         total_ff     <= TOTAL_RST;
         nonempty_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         init_ff      <= init_in;
         idx_ff       <= idx_in;
         pool_ff      <= pool_in;
         total_ff     <= total_in;
         nonempty_ff  <= nonempty_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      mode_ff       <= mode_in;
      left_ff       <= left_in;
      head_ff       <= head_in;
      tail_ff       <= tail_in;
      p_ff          <= p_in;
      b_ff          <= b_in;
      o_ff          <= o_in;
      want_ff       <= want_in;
      res_status_ff <= res_status_in;
      res_page_ff   <= res_page_in;
      res_order_ff  <= res_order_in;
      rsp_status_ff <= rsp_status_in;
      rsp_page_ff   <= rsp_page_in;
      rsp_order_ff  <= rsp_order_in;
   end

   always_comb begin
      hb_req = high_bit(req_bus.request_pages);
      want_c = hb_req;
      if (req_bus.request_pages > (CNT_W'(1) << hb_req)) want_c = hb_req + ORD_W'(1);
      avail = first_avail(nonempty_ff, want_c);
      hb_left = high_bit(left_ff);
      carve_ord = (hb_left > ORD_W'(MAX_ORDER)) ? ORD_W'(MAX_ORDER) : hb_left;
      buddy = p_ff ^ (PAGE_W'(1) << o_ff);
      ref_dec = meta_rd.refs - REF_W'(1);
   end

   always_comb begin
      state_in      = state_ff;
      mode_in       = mode_ff;
      init_in       = init_ff;
      idx_in        = idx_ff;
      left_in       = left_ff;
      pool_in       = pool_ff;
      total_in      = total_ff;
      nonempty_in   = nonempty_ff;
      head_in       = head_ff;
      tail_in       = tail_ff;
      p_in          = p_ff;
      b_in          = b_ff;
      o_in          = o_ff;
      want_in       = want_ff;
      res_status_in = res_status_ff;
      res_page_in   = res_page_ff;
      res_order_in  = res_order_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_status_in = rsp_status_ff;
      rsp_page_in   = rsp_page_ff;
      rsp_order_in  = rsp_order_ff;
      meta_we  = 1'b0;
      meta_wa  = '0;
      meta_wd  = '0;
      meta_ra  = '0;
      prev_we  = 1'b0;
      prev_wa  = '0;
      prev_wd  = '0;
      next_we  = 1'b0;
      next_wa  = '0;
      next_wd  = '0;
      link_ra  = '0;
      push_en  = 1'b0;
      push_pg  = '0;
      push_ord = '0;
      rm_en    = 1'b0;
      rm_pg    = '0;
      rm_ord   = '0;

      if (csr_bus.valid) total_in = csr_bus.total_pages;
      if (rsp_valid_ff && rsp_bus.ready) rsp_valid_in = 1'b0;

      unique case (state_ff)
         S_CLEAR: begin
            meta_we = 1'b1;
            meta_wa = idx_ff[PAGE_W-1:0];
            meta_wd = '{order: ORDER_NONE, free: 1'b0, refs: '0};
            idx_in  = idx_ff + CNT_W'(1);
            if (idx_ff == CNT_W'(NUM_PAGES - 1)) begin
               idx_in = '0;
               if (init_ff) begin
                  left_in  = pool_ff;
                  state_in = S_CARVE;
               end else begin
                  state_in = S_IDLE;
               end
            end
         end
         S_IDLE: begin
            if (req_fire) begin
               mode_in       = mode_type'(req_bus.mode);
               res_status_in = ST_OK;
               res_page_in   = '0;
               res_order_in  = '0;
               unique case (mode_type'(req_bus.mode))
                  MODE_INIT: begin
                     pool_in     = (total_ff > CNT_W'(NUM_PAGES)) ? CNT_W'(NUM_PAGES)
                                                                   : total_ff;
                     nonempty_in = '0;
                     idx_in      = '0;
                     init_in     = 1'b1;
                     state_in    = S_CLEAR;
                  end
                  MODE_ALLOC: begin
                     if (req_bus.request_pages == '0 || want_c > ORD_W'(MAX_ORDER) ||
                         !avail.found) begin
                        res_status_in = ST_NOMEM;
                        state_in      = S_RESP;
                     end else begin
                        p_in     = tail_ff[avail.idx];
                        o_in     = avail.idx;
                        want_in  = want_c;
                        link_ra  = tail_ff[avail.idx];
                        state_in = S_ALLOC_RM;
                     end
                  end
                  MODE_FREE, MODE_ADDREF: begin
                     res_page_in = req_bus.page_number;
                     p_in        = req_bus.page_number;
                     if ({1'b0, req_bus.page_number} >= pool_ff) begin
                        res_status_in = ST_INVALID;
                        state_in      = S_RESP;
                     end else begin
                        meta_ra  = req_bus.page_number;
                        state_in = S_CHECK;
                     end
                  end
                  default: state_in = S_IDLE;
               endcase
            end
         end
         S_CARVE: begin
            if (left_ff == '0) begin
               init_in  = 1'b0;
               state_in = S_RESP;
            end else begin
               push_en  = 1'b1;
               push_pg  = idx_ff[PAGE_W-1:0];
               push_ord = carve_ord;
               idx_in   = idx_ff + (CNT_W'(1) << carve_ord);
               left_in  = left_ff - (CNT_W'(1) << carve_ord);
            end
         end
         S_ALLOC_RM: begin
            rm_en    = 1'b1;
            rm_pg    = p_ff;
            rm_ord   = o_ff;
            state_in = (o_ff > want_ff) ? S_SPLIT : S_ALLOC_DONE;
         end
         S_SPLIT: begin
            push_en  = 1'b1;
            push_ord = o_ff - ORD_W'(1);
            push_pg  = p_ff + (PAGE_W'(1) << push_ord);
            o_in     = push_ord;
            if (push_ord == want_ff) state_in = S_ALLOC_DONE;
         end
         S_ALLOC_DONE: begin
            meta_we       = 1'b1;
            meta_wa       = p_ff;
            meta_wd       = '{order: SORD_W'(want_ff), free: 1'b0, refs: REF_W'(1)};
            res_page_in   = p_ff;
            res_order_in  = want_ff;
            state_in      = S_RESP;
         end
         S_CHECK: begin
            state_in = S_RESP;
            if (meta_rd.free) begin
               if (mode_ff == MODE_FREE) begin
                  res_status_in = ST_DOUBLE;
                  res_order_in  = meta_rd.order[ORD_W-1:0];
               end else begin
                  res_status_in = ST_INVALID;
               end
            end else if (meta_rd.order == ORDER_NONE || meta_rd.refs == '0) begin
               res_status_in = ST_INVALID;
            end else if (mode_ff == MODE_ADDREF) begin
               meta_we      = 1'b1;
               meta_wa      = p_ff;
               meta_wd      = meta_rd;
               if (meta_rd.refs != REF_MAX) meta_wd.refs = meta_rd.refs + REF_W'(1);
               res_order_in = meta_rd.order[ORD_W-1:0];
            end else begin
               meta_we      = 1'b1;
               meta_wa      = p_ff;
               meta_wd      = meta_rd;
               meta_wd.refs = ref_dec;
               if (ref_dec != '0) begin
                  res_status_in = ST_REFD;
                  res_order_in  = meta_rd.order[ORD_W-1:0];
               end else begin
                  o_in     = meta_rd.order[ORD_W-1:0];
                  state_in = S_MERGE;
               end
            end
         end
         S_MERGE: begin
            if (o_ff < ORD_W'(MAX_ORDER) && {1'b0, buddy} < pool_ff) begin
               b_in     = buddy;
               meta_ra  = buddy;
               link_ra  = buddy;
               state_in = S_MERGE_RD;
            end else begin
               state_in = S_PUSH;
            end
         end
         S_MERGE_RD: begin
            if (meta_rd.order == SORD_W'(o_ff) && meta_rd.free) begin
               rm_en    = 1'b1;
               rm_pg    = b_ff;
               rm_ord   = o_ff;
               meta_we  = 1'b1;
               meta_wa  = b_ff | p_ff;
               meta_wd  = '{order: ORDER_NONE, free: 1'b0, refs: '0};
               p_in     = p_ff & b_ff;
               o_in     = o_ff + ORD_W'(1);
               state_in = S_MERGE;
            end else begin
               state_in = S_PUSH;
            end
         end
         S_PUSH: begin
            push_en      = 1'b1;
            push_pg      = p_ff;
            push_ord     = o_ff;
            res_page_in  = p_ff;
            res_order_in = o_ff;
            state_in     = S_RESP;
         end
         S_RESP: begin
            if (!rsp_valid_ff || rsp_bus.ready) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_page_in   = res_page_ff;
               rsp_order_in  = res_order_ff;
               state_in      = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase

      // list tail insert
      if (push_en) begin
         meta_we = 1'b1;
         meta_wa = push_pg;
         meta_wd = '{order: SORD_W'(push_ord), free: 1'b1, refs: '0};
         if (nonempty_ff[push_ord]) begin
            next_we = 1'b1;
            next_wa = tail_ff[push_ord];
            next_wd = push_pg;
            prev_we = 1'b1;
            prev_wa = push_pg;
            prev_wd = tail_ff[push_ord];
         end else begin
            head_in[push_ord] = push_pg;
         end
         tail_in[push_ord]     = push_pg;
         nonempty_in[push_ord] = 1'b1;
      end

      // list unlink, links of rm_pg read the cycle before
      if (rm_en) begin
         if (head_ff[rm_ord] == rm_pg && tail_ff[rm_ord] == rm_pg) begin
            nonempty_in[rm_ord] = 1'b0;
         end else if (head_ff[rm_ord] == rm_pg) begin
            head_in[rm_ord] = next_rd;
         end else if (tail_ff[rm_ord] == rm_pg) begin
            tail_in[rm_ord] = prev_rd;
         end else begin
            next_we = 1'b1;
            next_wa = prev_rd;
            next_wd = next_rd;
            prev_we = 1'b1;
            prev_wa = next_rd;
            prev_wd = prev_rd;
         end
      end
   end

endmodule

`default_nettype wire

// ===== rtl/bpa_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none

module bpa_checker import bpa_pkg::*; (
   input wire logic              clock,
   input wire logic              reset,
   input wire logic              req_valid,
   input wire logic              req_ready,
   input wire logic              rsp_valid,
   input wire logic              rsp_ready,
   input wire logic [STAT_W-1:0] rsp_status,
   input wire logic [PAGE_W-1:0] rsp_page,
   input wire logic [ORD_W-1:0]  rsp_order
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status) && $stable(rsp_page) &&
                                  $stable(rsp_order))
      else $error("response changed while stalled");

   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while busy");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_status <= ST_DOUBLE && rsp_order <= ORD_W'(MAX_ORDER))
      else $error("response code out of range");

   a_nomem_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == ST_NOMEM |-> rsp_page == '0 && rsp_order == '0)
      else $error("no-memory response carries a block");

endmodule

bind buddy_page_allocator bpa_checker u_bpa_checker (
   .clock      (clock),
   .reset      (reset),
   .req_valid  (req_bus.valid),
   .req_ready  (req_bus.ready),
   .rsp_valid  (rsp_bus.valid),
   .rsp_ready  (rsp_bus.ready),
   .rsp_status (rsp_bus.status),
   .rsp_page   (rsp_bus.result_page),
   .rsp_order  (rsp_bus.result_order)
);

`default_nettype wire
